@@ hw/rtl/bba_pkg.sv @@
// Shared constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned NUM_BLOCKS  = 32;
    localparam int unsigned MEM_BYTES   = BLOCK_BYTES * NUM_BLOCKS;

    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int unsigned IDX_W       = $clog2(NUM_BLOCKS);
    localparam int unsigned CNT_W       = $clog2(NUM_BLOCKS + 1);

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 15;
    localparam int unsigned BYTES_W = 15;

    typedef logic [NUM_BLOCKS-1:0] block_map_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_NO_ROOM   = 2'd2,
        STATUS_OUTSIDE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_CHECK,
        ST_ALLOC_SCAN,
        ST_FREE_CHECK,
        ST_FREE_APPLY,
        ST_SPAN_SCAN,
        ST_DONE
    } state_t;

    // Mask with the low cnt bits set; a count of NUM_BLOCKS gives all ones.
    function automatic block_map_t ones_mask(input logic [CNT_W-1:0] cnt);
        block_map_t all_ones;
        all_ones  = '1;
        ones_mask = ~(all_ones << cnt);
    endfunction

    // Byte count of a number of blocks, in the width of the byte fields.
    function automatic logic [BYTES_W-1:0] blocks_to_bytes(input logic [CNT_W-1:0] cnt);
        blocks_to_bytes = BYTES_W'(cnt) << BLOCK_SHIFT;
    endfunction

endpackage

@@ hw/rtl/bitmap_block_allocator.sv @@
// First-fit bitmap block allocator: sequencer, occupancy map and result register.
// An allocate runs the size check, the window scan if the check passes (the test past the top
// included) and the span scan; a free runs the address check, the apply step if inside memory
// and the span scan. One item at a time: the next transfer can come in the cycle after
// the result loads. The window scan and the span scan visit one block position per cycle.
// Reset (aresetn low, synchronous): all blocks free, run table cleared, base address 0.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [SIZE_W-1:0]    s_size_bytes,
    input  logic [ADDR_W-1:0]    s_address,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [ADDR_W-1:0]    m_alloc_address,
    output logic [BYTES_W-1:0]   m_free_bytes,
    output logic [BYTES_W-1:0]   m_largest_free_bytes
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  base_reg;
    block_map_t         occ_reg, occ_next;
    logic [CNT_W-1:0]   run_len_reg [NUM_BLOCKS];
    logic [BYTES_W-1:0] free_total_reg, free_total_next;

    logic               rl_wr_en;
    logic [IDX_W-1:0]   rl_wr_idx;
    logic [CNT_W-1:0]   rl_wr_data;

    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   nblk_reg, nblk_next;
    block_map_t         mask_reg, mask_next;
    logic [CNT_W-1:0]   win_idx_reg, win_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  alloc_addr_reg, alloc_addr_next;

    logic [IDX_W-1:0]   span_idx_reg, span_idx_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]   best_reg, best_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg;
    logic [ADDR_W-1:0]  m_alloc_addr_reg;
    logic [BYTES_W-1:0] m_free_bytes_reg;
    logic [BYTES_W-1:0] m_largest_reg;

    logic               accept;
    logic               load_out;

    // Datapath helpers.
    logic [SIZE_W:0]    size_round;
    logic [CNT_W-1:0]   size_blocks;
    logic [CNT_W:0]     win_end;
    logic               win_fits;
    logic               win_clear;
    logic [ADDR_W:0]    addr_diff;
    logic               addr_inside;
    logic [CNT_W-1:0]   free_len;
    logic [CNT_W-1:0]   cur_inc;
    logic               span_last;

    assign size_round  = {1'b0, size_reg} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
    // The size is already known to fit in memory, so the block count fits CNT_W.
    assign size_blocks = size_round[BLOCK_SHIFT +: CNT_W];
    assign win_end     = {1'b0, win_idx_reg} + {1'b0, nblk_reg};
    assign win_fits    = (win_end <= (CNT_W + 1)'(NUM_BLOCKS));
    assign win_clear   = ((occ_reg & mask_reg) == '0);
    assign addr_diff   = {1'b0, addr_reg} - {1'b0, base_reg};
    assign addr_inside = !addr_diff[ADDR_W] && (addr_diff[ADDR_W-1:0] < ADDR_W'(MEM_BYTES));
    assign free_len    = run_len_reg[free_idx_reg];
    assign cur_inc     = cur_reg + CNT_W'(1);
    assign span_last   = (span_idx_reg == IDX_W'(NUM_BLOCKS - 1));

    // Handshake and result register control.
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        accept   = s_valid && s_ready;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = s_cmd ? ST_FREE_CHECK : ST_ALLOC_CHECK;
                end
            end
            ST_ALLOC_CHECK: begin
                if ((32'(size_reg) > MEM_BYTES) || (size_reg > free_total_reg) ||
                    (size_reg == '0)) begin
                    state_next = ST_SPAN_SCAN;
                end else begin
                    state_next = ST_ALLOC_SCAN;
                end
            end
            ST_ALLOC_SCAN: begin
                if (!win_fits || win_clear) begin
                    state_next = ST_SPAN_SCAN;
                end
            end
            ST_FREE_CHECK: begin
                state_next = addr_inside ? ST_FREE_APPLY : ST_SPAN_SCAN;
            end
            ST_FREE_APPLY: begin
                state_next = ST_SPAN_SCAN;
            end
            ST_SPAN_SCAN: begin
                if (span_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        size_next       = size_reg;
        addr_next       = addr_reg;
        nblk_next       = nblk_reg;
        mask_next       = mask_reg;
        win_idx_next    = win_idx_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        alloc_addr_next = alloc_addr_reg;
        span_idx_next   = span_idx_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        occ_next        = occ_reg;
        free_total_next = free_total_reg;
        rl_wr_en        = 1'b0;
        rl_wr_idx       = free_idx_reg;
        rl_wr_data      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    size_next       = s_size_bytes;
                    addr_next       = s_address;
                    status_next     = STATUS_OK;
                    alloc_addr_next = '0;
                    span_idx_next   = '0;
                    cur_next        = '0;
                    best_next       = '0;
                end
            end
            ST_ALLOC_CHECK: begin
                if (32'(size_reg) > MEM_BYTES) begin
                    status_next = STATUS_TOO_LARGE;
                end else if (size_reg > free_total_reg) begin
                    status_next = STATUS_NO_ROOM;
                end else if (size_reg == '0) begin
                    alloc_addr_next = base_reg;
                end else begin
                    nblk_next    = size_blocks;
                    mask_next    = ones_mask(size_blocks);
                    win_idx_next = '0;
                end
            end
            ST_ALLOC_SCAN: begin
                if (!win_fits) begin
                    status_next = STATUS_NO_ROOM;
                end else if (win_clear) begin
                    occ_next        = occ_reg | mask_reg;
                    free_total_next = free_total_reg - blocks_to_bytes(nblk_reg);
                    rl_wr_en        = 1'b1;
                    rl_wr_idx       = win_idx_reg[IDX_W-1:0];
                    rl_wr_data      = nblk_reg;
                    alloc_addr_next = base_reg + (ADDR_W'(win_idx_reg) << BLOCK_SHIFT);
                end else begin
                    mask_next    = mask_reg << 1;
                    win_idx_next = win_idx_reg + CNT_W'(1);
                end
            end
            ST_FREE_CHECK: begin
                if (!addr_inside) begin
                    status_next = STATUS_OUTSIDE;
                end else begin
                    free_idx_next = addr_diff[BLOCK_SHIFT +: IDX_W];
                end
            end
            ST_FREE_APPLY: begin
                // An address whose block starts no run leaves everything as it is.
                if (free_len != '0) begin
                    occ_next        = occ_reg & ~(ones_mask(free_len) << free_idx_reg);
                    free_total_next = free_total_reg + blocks_to_bytes(free_len);
                    rl_wr_en        = 1'b1;
                    rl_wr_idx       = free_idx_reg;
                    rl_wr_data      = '0;
                end
            end
            ST_SPAN_SCAN: begin
                span_idx_next = span_idx_reg + IDX_W'(1);
                if (occ_reg[span_idx_reg]) begin
                    cur_next = '0;
                end else begin
                    cur_next = cur_inc;
                    if (cur_inc > best_reg) begin
                        best_next = cur_inc;
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state and allocator bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            base_reg       <= '0;
            occ_reg        <= '0;
            free_total_reg <= BYTES_W'(MEM_BYTES);
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                run_len_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            occ_reg        <= occ_next;
            free_total_reg <= free_total_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (rl_wr_en) begin
                run_len_reg[rl_wr_idx] <= rl_wr_data;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        nblk_reg       <= nblk_next;
        mask_reg       <= mask_next;
        win_idx_reg    <= win_idx_next;
        free_idx_reg   <= free_idx_next;
        status_reg     <= status_next;
        alloc_addr_reg <= alloc_addr_next;
        span_idx_reg   <= span_idx_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        if (load_out) begin
            m_status_reg     <= status_reg;
            m_alloc_addr_reg <= alloc_addr_reg;
            m_free_bytes_reg <= free_total_reg;
            m_largest_reg    <= blocks_to_bytes(best_reg);
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_alloc_address      = m_alloc_addr_reg;
    assign m_free_bytes         = m_free_bytes_reg;
    assign m_largest_free_bytes = m_largest_reg;

endmodule
